>>> sv/assert_macros.svh
// Assertion helpers used by the checker.
// Each macro samples on the rising edge of clk_i and stays quiet while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: the consequent holds whenever the antecedent holds.
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: the consequent holds in the cycle after the antecedent.
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

  // Field widths of the stream payloads
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned OUT_PAD_W  = OUT_TDATA_W - VALUE_W - 2;

  // Operation codes carried on the input tuser
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // Result status codes carried on the output tuser
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  // Value reported by a remove from an empty queue
  localparam logic [VALUE_W-1:0] EMPTY_REMOVE_VALUE = '1;

  // Read address source of the entry memory
  typedef enum logic [1:0] {
    RD_HEAD,
    RD_TAIL_PREV,
    RD_SCAN_PREV
  } rd_sel_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    in_ready;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    ins_start;
    logic    shift;
    logic    put;
    logic    pop;
    logic    take;
    logic    reject_full;
    logic    reject_empty;
    logic    publish;
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_remove;
    logic full;
    logic empty;
    logic less;
    logic rem_last;
    logic out_busy;
  } dp_status_t;

endpackage

>>> sv/spq_ctrl.sv
`timescale 1ns / 1ps

module spq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid_i,
  input  spq_pkg::dp_status_t sts_i,
  output spq_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_CMP,
    S_INS_PUT,
    S_RM_WAIT,
    S_FIN
  } state_e;

  state_e state_q, state_d;

  // Decode commands and next state
  always_comb begin
    cmd_o   = '0;
    cmd_o.rd_sel = spq_pkg::RD_HEAD;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (s_tvalid_i) begin
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts_i.is_remove) begin
          if (sts_i.empty) begin
            cmd_o.reject_empty = 1'b1;
            state_d = S_FIN;
          end else begin
            // Read the head, then retire it
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = spq_pkg::RD_HEAD;
            cmd_o.pop    = 1'b1;
            state_d = S_RM_WAIT;
          end
        end else if (sts_i.full) begin
          cmd_o.reject_full = 1'b1;
          state_d = S_FIN;
        end else begin
          cmd_o.ins_start = 1'b1;
          if (sts_i.empty) begin
            state_d = S_INS_PUT;
          end else begin
            // Fetch the last entry as the first candidate
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = spq_pkg::RD_TAIL_PREV;
            state_d = S_INS_CMP;
          end
        end
      end
      S_INS_CMP: begin
        if (sts_i.less) begin
          // Move the smaller entry one slot back
          cmd_o.shift = 1'b1;
          if (sts_i.rem_last) begin
            state_d = S_INS_PUT;
          end else begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = spq_pkg::RD_SCAN_PREV;
          end
        end else begin
          cmd_o.put = 1'b1;
          state_d = S_FIN;
        end
      end
      S_INS_PUT: begin
        cmd_o.put = 1'b1;
        state_d = S_FIN;
      end
      S_RM_WAIT: begin
        cmd_o.take = 1'b1;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o.publish = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> sv/spq_datapath.sv
`timescale 1ns / 1ps

module spq_datapath #(
  parameter int unsigned DEPTH = 128
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  spq_pkg::ctrl_cmd_t                   cmd_i,
  output spq_pkg::dp_status_t                  sts_o,
  input  logic                                 s_tvalid_i,
  input  logic [spq_pkg::VALUE_W-1:0]          s_tdata_i,
  input  logic                                 s_tuser_i,
  input  logic                                 m_tready_i,
  output logic                                 m_tvalid_o,
  output logic [spq_pkg::OUT_TDATA_W-1:0]      m_tdata_o,
  output logic [spq_pkg::STATUS_W-1:0]         m_tuser_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == LAST_SLOT) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    return (p == '0) ? LAST_SLOT : p - AW'(1);
  endfunction

  // Entries live in a ring from head_q (largest) to tail_q (next free slot)
  logic [spq_pkg::VALUE_W-1:0] mem_q [DEPTH];

  logic [AW-1:0]  head_q, tail_q, scan_q, hole_q, raddr;
  logic [CW-1:0]  count_q, rem_q;
  logic           cmd_q;
  logic signed [spq_pkg::VALUE_W-1:0] value_q, rdata_q;
  logic [spq_pkg::STATUS_W-1:0] res_status_q, out_status_q;
  logic [spq_pkg::VALUE_W-1:0]  res_value_q, out_value_q;
  logic           out_valid_q, out_full_q, out_empty_q;
  logic           accept;

  assign accept = s_tvalid_i & cmd_i.in_ready;

  // Status toward the controller
  assign sts_o.is_remove = (cmd_q == spq_pkg::CMD_REMOVE);
  assign sts_o.full      = (count_q == CW'(DEPTH));
  assign sts_o.empty     = (count_q == '0);
  assign sts_o.less      = (rdata_q < value_q);
  assign sts_o.rem_last  = (rem_q == CW'(1));
  assign sts_o.out_busy  = out_valid_q & ~m_tready_i;

  // Select the read address
  always_comb begin
    unique case (cmd_i.rd_sel)
      spq_pkg::RD_HEAD:      raddr = head_q;
      spq_pkg::RD_TAIL_PREV: raddr = ptr_dec(tail_q);
      spq_pkg::RD_SCAN_PREV: raddr = ptr_dec(scan_q);
      default:               raddr = head_q;
    endcase
  end

  // Entry memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.shift || cmd_i.put) begin
      mem_q[hole_q] <= cmd_i.shift ? rdata_q : value_q;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // Capture the accepted transaction
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= s_tuser_i;
      value_q <= s_tdata_i;
    end
  end

  // Advance ring pointers, fill count and insert scan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      scan_q  <= '0;
      hole_q  <= '0;
      rem_q   <= '0;
    end else begin
      if (cmd_i.ins_start) begin
        hole_q <= tail_q;
        scan_q <= ptr_dec(tail_q);
        rem_q  <= count_q;
      end
      if (cmd_i.shift) begin
        hole_q <= scan_q;
        scan_q <= ptr_dec(scan_q);
        rem_q  <= rem_q - CW'(1);
      end
      if (cmd_i.put) begin
        tail_q  <= ptr_inc(tail_q);
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.pop) begin
        head_q  <= ptr_inc(head_q);
        count_q <= count_q - CW'(1);
      end
    end
  end

  // Build the result of the current transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.put) begin
      res_status_q <= spq_pkg::STATUS_OK;
      res_value_q  <= '0;
    end else if (cmd_i.take) begin
      res_status_q <= spq_pkg::STATUS_OK;
      res_value_q  <= rdata_q;
    end else if (cmd_i.reject_full) begin
      res_status_q <= spq_pkg::STATUS_FULL;
      res_value_q  <= '0;
    end else if (cmd_i.reject_empty) begin
      res_status_q <= spq_pkg::STATUS_EMPTY;
      res_value_q  <= spq_pkg::EMPTY_REMOVE_VALUE;
    end
  end

  // Output register: load on publish, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.publish) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      out_status_q <= res_status_q;
      out_value_q  <= res_value_q;
      out_full_q   <= sts_o.full;
      out_empty_q  <= sts_o.empty;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tuser_o  = out_status_q;
  assign m_tdata_o  = {{spq_pkg::OUT_PAD_W{1'b0}}, out_empty_q, out_full_q, out_value_q};

endmodule

>>> sv/sorted_priority_queue.sv
// Sorted max-first priority queue, one transaction in flight at a time.
// Each transaction runs from S_IDLE through S_DISPATCH to S_FIN, which publishes the result.
// A remove reads and pops the head via S_RM_WAIT, a rejected insert or remove goes straight
// to S_FIN, and an insert scans from the tail, shifting each entry smaller than the new value.
// S_FIN waits while the output register is stalled by m_axis_tready; the insert scan moves one entry per cycle.
// Reset (async, active low) empties the queue; entry memory contents are not cleared.
`timescale 1ns / 1ps

module sorted_priority_queue #(
  parameter int unsigned DEPTH = 128
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [spq_pkg::VALUE_W-1:0]      s_axis_tdata,  // [31:0] value
  input  logic                             s_axis_tuser,  // [0] cmd
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [31:0] removed_value, [32] now_full, [33] now_empty, [39:34] zero
  output logic [spq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic [spq_pkg::STATUS_W-1:0]     m_axis_tuser   // [1:0] status
);

  spq_pkg::ctrl_cmd_t  cmd;
  spq_pkg::dp_status_t sts;

  assign s_axis_tready = cmd.in_ready;

  spq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  spq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .s_tvalid_i (s_axis_tvalid),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser)
  );

endmodule

>>> sv/spq_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module spq_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [spq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input logic [spq_pkg::STATUS_W-1:0]     m_axis_tuser
);

  // Hold a stalled result
  `ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
              m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
              "stalled result changed")

  // Close the input after each transaction
  `ASSERT_NXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready,
              "second transaction taken while busy")

  // A rejected insert reports a full queue and a zero value
  `ASSERT_IMP(a_full_reject, m_axis_tvalid && m_axis_tuser == spq_pkg::STATUS_FULL,
              m_axis_tdata[32] && m_axis_tdata[31:0] == '0,
              "full reject inconsistent")

  // A remove on empty reports an empty queue and all ones
  `ASSERT_IMP(a_empty_remove, m_axis_tvalid && m_axis_tuser == spq_pkg::STATUS_EMPTY,
              m_axis_tdata[33] && m_axis_tdata[31:0] == spq_pkg::EMPTY_REMOVE_VALUE,
              "empty remove inconsistent")

  // Full and empty never show together
  `ASSERT_IMP(a_flags_exclusive, m_axis_tvalid, !(m_axis_tdata[32] && m_axis_tdata[33]),
              "full and empty both set")

endmodule

bind sorted_priority_queue spq_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
